// ----- hw/rtl/wfm_pkg.sv -----
// shared types and constants of the waveform frequency meter
package wfm_pkg;

    localparam int SAMPLE_IN_W = 12;
    localparam int ELAPSED_W   = 8;
    localparam int WINDOW_W    = 20;
    localparam int TIMER_W     = 24;
    localparam int FREQ_W      = 30;
    localparam int PCOUNT_W    = 4;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 20'd1000000;
    localparam logic [FREQ_W-1:0]   FREQ_NUM     = 30'd998600000;

    // finished measurement handed from the front end to the divider
    typedef struct packed {
        logic               timed_out;
        logic [TIMER_W-1:0] time_us;
    } t_meas;

endpackage

// ----- hw/rtl/wfm_front.sv -----
// front end: window, quartile thresholds, alignment and period counting
module wfm_front #(
    parameter int SAMPLE_BITS  = 12,
    parameter int PERIOD_COUNT = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr,
    input  logic [wfm_pkg::WINDOW_W-1:0]  i_cfg_data,
    input  logic                          i_item,
    input  logic                          i_action,
    input  logic [wfm_pkg::SAMPLE_IN_W-1:0] i_sample,
    input  logic [wfm_pkg::ELAPSED_W-1:0] i_elapsed,
    output logic                          o_req_valid,
    output wfm_pkg::t_meas                o_req
);
    import wfm_pkg::*;

    localparam int SW = SAMPLE_BITS;
    localparam logic [PCOUNT_W-1:0] PC = PCOUNT_W'(PERIOD_COUNT);

    typedef enum logic [5:0] {
        PH_IDLE       = 6'b000001,
        PH_WINDOW     = 6'b000010,
        PH_ALIGN_LOW  = 6'b000100,
        PH_ALIGN_HIGH = 6'b001000,
        PH_COUNT_LOW  = 6'b010000,
        PH_COUNT_HIGH = 6'b100000
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [WINDOW_W-1:0]   r_window;
    logic [TIMER_W-1:0]    r_limit;
    logic [SW-1:0]         r_min, n_min, r_max, n_max;
    logic [SW-1:0]         r_lq, n_lq, r_hq, n_hq;
    logic [TIMER_W-1:0]    r_timer, n_timer;
    logic [PCOUNT_W-1:0]   r_pd, n_pd;
    logic                  r_req_valid, n_req_valid;
    t_meas                 r_req, n_req;

    logic [31:0]           w_s32;
    logic [SW-1:0]         w_s;
    logic [TIMER_W:0]      w_tsum;
    logic [TIMER_W-1:0]    w_t;
    logic [SW+1:0]         w_lq_sum, w_hq_sum;
    logic [PCOUNT_W-1:0]   w_pd_inc;

    assign w_s32    = 32'(i_sample);
    assign w_s      = w_s32[SW-1:0];
    assign w_tsum   = {1'b0, r_timer} + (TIMER_W+1)'(i_elapsed);
    assign w_t      = w_tsum[TIMER_W] ? {TIMER_W{1'b1}} : w_tsum[TIMER_W-1:0];
    // 3*min + max and min + 3*max
    assign w_lq_sum = {2'b00, r_min} + {1'b0, r_min, 1'b0} + {2'b00, r_max};
    assign w_hq_sum = {2'b00, r_max} + {1'b0, r_max, 1'b0} + {2'b00, r_min};
    assign w_pd_inc = r_pd + PCOUNT_W'(1);

    always_comb begin
        n_phase     = r_phase;
        n_min       = r_min;
        n_max       = r_max;
        n_lq        = r_lq;
        n_hq        = r_hq;
        n_timer     = r_timer;
        n_pd        = r_pd;
        n_req_valid = 1'b0;
        n_req       = r_req;
        if (i_item) begin
            if (!i_action) begin
                n_min   = w_s;
                n_max   = w_s;
                n_timer = '0;
                n_pd    = '0;
                n_phase = PH_WINDOW;
            end else begin
                n_timer = w_t;
                case (r_phase)
                    PH_IDLE: begin
                        n_timer = r_timer;
                    end
                    PH_WINDOW: begin
                        if (w_t >= TIMER_W'(r_window)) begin
                            n_lq    = w_lq_sum[SW+1:2];
                            n_hq    = w_hq_sum[SW+1:2];
                            n_timer = '0;
                            n_phase = PH_ALIGN_LOW;
                        end else begin
                            if (w_s > r_max) n_max = w_s;
                            if (w_s < r_min) n_min = w_s;
                        end
                    end
                    PH_ALIGN_LOW, PH_ALIGN_HIGH: begin
                        if (r_phase == PH_ALIGN_LOW && w_s <= r_lq) begin
                            n_phase = PH_ALIGN_HIGH;
                        end
                        // a rise above q3 or the timeout starts counting
                        if ((r_phase == PH_ALIGN_HIGH && w_s > r_hq) || w_t >= r_limit) begin
                            n_timer = '0;
                            n_pd    = '0;
                            n_phase = PH_COUNT_LOW;
                        end
                    end
                    PH_COUNT_LOW, PH_COUNT_HIGH: begin
                        if (w_t >= r_limit) begin
                            n_req_valid       = 1'b1;
                            n_req.timed_out   = 1'b1;
                            n_req.time_us     = w_t;
                            n_phase           = PH_IDLE;
                        end else if (r_phase == PH_COUNT_LOW) begin
                            if (w_s <= r_lq) n_phase = PH_COUNT_HIGH;
                        end else if (w_s > r_hq) begin
                            n_pd = w_pd_inc;
                            if (w_pd_inc >= PC) begin
                                n_req_valid     = 1'b1;
                                n_req.timed_out = 1'b0;
                                n_req.time_us   = w_t;
                                n_phase         = PH_IDLE;
                            end else begin
                                n_phase = PH_COUNT_LOW;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_window    <= WINDOW_RESET;
            r_limit     <= TIMER_W'(WINDOW_RESET) * TIMER_W'(10);
            r_min       <= '0;
            r_max       <= '0;
            r_lq        <= '0;
            r_hq        <= '0;
            r_timer     <= '0;
            r_pd        <= '0;
            r_req_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_min       <= n_min;
            r_max       <= n_max;
            r_lq        <= n_lq;
            r_hq        <= n_hq;
            r_timer     <= n_timer;
            r_pd        <= n_pd;
            r_req_valid <= n_req_valid;
            if (i_cfg_wr) begin
                r_window <= i_cfg_data;
                // timeout limit is ten windows: 8w + 2w
                r_limit  <= {1'b0, i_cfg_data, 3'b000} + {3'b000, i_cfg_data, 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
    end

    assign o_req_valid = r_req_valid;
    assign o_req       = r_req;

endmodule

// ----- hw/rtl/wfm_queue.sv -----
// two-entry queue of finished measurements between front end and divider
module wfm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wfm_pkg::t_meas i_push_data,
    output logic           o_full,
    output logic           o_valid,
    output wfm_pkg::t_meas o_data,
    input  logic           i_pop
);
    import wfm_pkg::*;

    t_meas       r_mem [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_count;
    logic        w_push, w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_push_data;
    end

endmodule

// ----- hw/rtl/wfm_back.sv -----
// back end: restoring divider for the frequency and the output register
module wfm_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  wfm_pkg::t_meas              i_req,
    output logic                        o_req_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [wfm_pkg::TIMER_W-1:0] o_time_us,
    output logic [wfm_pkg::FREQ_W-1:0]  o_freq,
    output logic                        o_timed_out
);
    import wfm_pkg::*;

    localparam logic [4:0] STEPS = 5'(FREQ_W);

    logic                r_busy;
    logic [4:0]          r_cnt;
    logic [FREQ_W-1:0]   r_q;
    logic [TIMER_W-1:0]  r_rem;
    t_meas               r_job;
    logic                r_ovalid;
    logic [TIMER_W-1:0]  r_otime;
    logic [FREQ_W-1:0]   r_ofreq;
    logic                r_oflag;

    logic [TIMER_W:0]    w_shift;
    logic                w_ge;
    logic [TIMER_W:0]    w_diff;
    logic                w_out_free;
    logic                w_finish;

    assign w_shift    = {r_rem, r_q[FREQ_W-1]};
    assign w_ge       = (w_shift >= {1'b0, r_job.time_us});
    assign w_diff     = w_shift - {1'b0, r_job.time_us};
    assign w_out_free = !r_ovalid || i_ready;
    assign w_finish   = r_busy && (r_cnt == STEPS) && w_out_free;
    assign o_req_pop  = !r_busy && i_req_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_req_pop) begin
                r_busy <= 1'b1;
                // zero time skips the division and returns FREQ_NUM unchanged
                r_cnt  <= (i_req.time_us == '0) ? STEPS : 5'd0;
            end else if (r_busy && r_cnt != STEPS) begin
                r_cnt <= r_cnt + 5'd1;
            end else if (w_finish) begin
                r_busy <= 1'b0;
            end
            if (w_finish)     r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_pop) begin
            r_job <= i_req;
            r_q   <= FREQ_NUM;
            r_rem <= '0;
        end else if (r_busy && r_cnt != STEPS) begin
            r_q   <= {r_q[FREQ_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[TIMER_W-1:0] : w_shift[TIMER_W-1:0];
        end
        if (w_finish) begin
            r_otime <= r_job.time_us;
            r_ofreq <= r_q;
            r_oflag <= r_job.timed_out;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_time_us   = r_otime;
    assign o_freq      = r_ofreq;
    assign o_timed_out = r_oflag;

endmodule

// ----- hw/rtl/waveform_frequency_meter_top.sv -----
// waveform frequency meter: period counter with quartile hysteresis
// input items are taken one per cycle while the two-entry result queue has room
// a result goes from the front end's request register through the queue to the divider (zero time skips it):
// the 30-step restoring divider, one quotient bit per cycle, then the output register
// reset is synchronous active low: phase idle, state and queue cleared, window 1000000 us
module waveform_frequency_meter_top #(
    parameter int SAMPLE_BITS  = 12,
    parameter int PERIOD_COUNT = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [19:0] i_cfg_data,   // window_us
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,    // sample[11:0], elapsed_us[19:12], zero pad
    input  logic        i_s_tuser,    // action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,    // ten_period_us[23:0], frequency_centihz[53:24], pad
    output logic        o_m_tuser     // timed_out
);
    import wfm_pkg::*;

    logic                w_item;
    logic                w_req_valid;
    t_meas               w_req;
    logic                w_q_full;
    logic                w_q_valid;
    t_meas               w_q_data;
    logic                w_q_pop;
    logic [TIMER_W-1:0]  w_time;
    logic [FREQ_W-1:0]   w_freq;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !w_q_full;
    assign w_item      = i_s_tvalid && o_s_tready;

    wfm_front #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .PERIOD_COUNT (PERIOD_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_item      (w_item),
        .i_action    (i_s_tuser),
        .i_sample    (i_s_tdata[11:0]),
        .i_elapsed   (i_s_tdata[19:12]),
        .o_req_valid (w_req_valid),
        .o_req       (w_req)
    );

    wfm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_req_valid),
        .i_push_data (w_req),
        .o_full      (w_q_full),
        .o_valid     (w_q_valid),
        .o_data      (w_q_data),
        .i_pop       (w_q_pop)
    );

    wfm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_q_valid),
        .i_req       (w_q_data),
        .o_req_pop   (w_q_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_time_us   (w_time),
        .o_freq      (w_freq),
        .o_timed_out (o_m_tuser)
    );

    assign o_m_tdata = {2'b00, w_freq, w_time};

endmodule
